/* hw/rtl/masked_patch_distance_top_assert.svh */
// Assertion macros for the masked patch distance block.
`ifndef MASKED_PATCH_DISTANCE_TOP_ASSERT_SVH
`define MASKED_PATCH_DISTANCE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define MPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPD_ASSERT_IMP(lbl, ante, cons, msg)
`define MPD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/mpd_pkg.sv */
// Shared constants and types for the masked patch distance block.
package mpd_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 7;

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW      = $clog2(((MAX_DIM > 256) ? MAX_DIM : 256) + MAX_RADIUS + 1) + 1;
  localparam int RW      = $clog2(MAX_RADIUS + 1);
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(DEPTH);

  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W + 1;
  localparam int MASK_BIT = 3 * CHAN_W;
  localparam int SQ_W     = 2 * CHAN_W;
  localparam int SQ3_W    = SQ_W + 2;

  localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int SUM_W   = $clog2(WIN_MAX * 195075 + 1);
  localparam int COUNT_W = $clog2(WIN_MAX + 1);
  localparam int FRAC_W  = 8;
  localparam int DIVD_W  = SUM_W + FRAC_W;
  localparam int DCNT_W  = $clog2(DIVD_W + 1);

  localparam int MEAN_OUT_W  = 26;
  localparam int SUM_OUT_W   = 26;
  localparam int COUNT_OUT_W = 8;
  localparam int COORD_IN_W  = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int DIM_REG_W  = 9;
  localparam int RAD_REG_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATCH_RADIUS = 2'd2;

  localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 9'd256;
  localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 9'd256;
  localparam logic [RAD_REG_W-1:0] RADIUS_RESET = 3'd1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [PIX_W-1:0]     pixel_t;
  typedef logic [AW-1:0]        addr_t;

endpackage

/* hw/rtl/mpd_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module mpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/masked_patch_distance_top.sv */
// Top level of the masked patch distance block: pixel store, window walk and divider.
//
// Usage:
//   Input channel (in_valid/in_ready) carries write and query items. A write
//   item stores one pixel (RGB plus mask) and gives no result.
//   A query item compares the windows around the target and source centers.
//   Output channel (out_valid/out_ready) gives one result per query.
//   Configuration channel (cfg_valid/cfg_ready) is ready outside reset; write
//   it only while no query is in flight.
// Query flow:
//   A query runs the center check, walks the (2r+1)^2 window, where r is the
//   radius, then drains the pipeline and runs the bit-serial divider
//   (one quotient bit per cycle). Two copies of the pixel memory give one
//   target and one source pixel per cycle. A bad source center ends the
//   query after the center check, a masked one after the S_CWAIT state.
//   Queries run one at a time; writes are taken only while no query runs.
// Reset clears the control state and sets the registers to 256, 256, 1; the
// pixel memory is not cleared and must be written before it is read.
// A stalled receiver holds the result in the output register; the block
// still takes write items, and a finished query waits until the output frees.
`include "masked_patch_distance_top_assert.svh"

module masked_patch_distance_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mpd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mpd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 command,
  input  logic [mpd_pkg::COORD_IN_W-1:0]       target_x,
  input  logic [mpd_pkg::COORD_IN_W-1:0]       target_y,
  input  logic [mpd_pkg::COORD_IN_W-1:0]       source_x,
  input  logic [mpd_pkg::COORD_IN_W-1:0]       source_y,
  input  logic [mpd_pkg::CHAN_W-1:0]           red,
  input  logic [mpd_pkg::CHAN_W-1:0]           green,
  input  logic [mpd_pkg::CHAN_W-1:0]           blue,
  input  logic                                 masked,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mpd_pkg::MEAN_OUT_W-1:0]       mean_distance,
  output logic [mpd_pkg::SUM_OUT_W-1:0]        squared_sum,
  output logic [mpd_pkg::COUNT_OUT_W-1:0]      sample_count,
  output logic                                 bad_match
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_CWAIT  = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  localparam int CW      = mpd_pkg::CW;
  localparam int RW      = mpd_pkg::RW;
  localparam int AW      = mpd_pkg::AW;
  localparam int SUM_W   = mpd_pkg::SUM_W;
  localparam int COUNT_W = mpd_pkg::COUNT_W;
  localparam int DIVD_W  = mpd_pkg::DIVD_W;
  localparam int DCNT_W  = mpd_pkg::DCNT_W;
  localparam int CHAN_W  = mpd_pkg::CHAN_W;
  localparam int SQ_W    = mpd_pkg::SQ_W;
  localparam int SQ3_W   = mpd_pkg::SQ3_W;

  localparam mpd_pkg::coord_t MAX_W_C = CW'(mpd_pkg::MAX_WIDTH);
  localparam mpd_pkg::coord_t MAX_H_C = CW'(mpd_pkg::MAX_HEIGHT);
  localparam logic signed [RW:0] ONE_D = (RW + 1)'(1);

  function automatic mpd_pkg::addr_t pix_addr(input mpd_pkg::coord_t x,
                                              input mpd_pkg::coord_t y);
    pix_addr = AW'($unsigned(y)) * AW'(mpd_pkg::MAX_WIDTH) + AW'($unsigned(x));
  endfunction

  logic [mpd_pkg::DIM_REG_W-1:0] width_reg;
  logic [mpd_pkg::DIM_REG_W-1:0] height_reg;
  logic [mpd_pkg::RAD_REG_W-1:0] radius_reg;
  mpd_pkg::coord_t               w_sat;
  mpd_pkg::coord_t               h_sat;
  logic [RW-1:0]                 r_sat;
  logic signed [RW:0]            r_pos;

  logic [2:0]                    state;
  mpd_pkg::coord_t               tx, ty, sx, sy;
  logic signed [RW:0]            dx, dy;
  mpd_pkg::coord_t               wx_t, wy_t, wx_s, wy_s;
  logic                          win_use;
  logic                          center_ok;

  logic                          in_accept;
  logic                          write_ok;
  logic                          we;
  mpd_pkg::addr_t                waddr;
  mpd_pkg::pixel_t               wdata;
  mpd_pkg::addr_t                raddr_t, raddr_s;
  mpd_pkg::pixel_t               rdata_t, rdata_s;

  logic                          p1_valid, p1_use;
  logic                          p2_valid;
  logic signed [CHAN_W:0]        dch [3];
  logic signed [2*CHAN_W+1:0]    pch [3];
  logic [SQ_W-1:0]               sq_next [3];
  logic [SQ_W-1:0]               sq [3];
  logic [SQ3_W-1:0]              sq3;
  logic                          pair_ok;

  logic [SUM_W-1:0]              sum_acc;
  logic [COUNT_W-1:0]            cnt_acc;
  logic                          bad;

  logic [DIVD_W-1:0]             quo;
  logic [COUNT_W-1:0]            rem;
  logic [COUNT_W:0]              rem_sh;
  logic                          geq;
  logic [COUNT_W-1:0]            rem_next;
  logic [DCNT_W-1:0]             div_cnt;
  logic                          out_free;

  assign cfg_ready = !rst;
  assign in_ready  = !rst && (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= mpd_pkg::WIDTH_RESET;
      height_reg <= mpd_pkg::HEIGHT_RESET;
      radius_reg <= mpd_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mpd_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
        mpd_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
        mpd_pkg::REG_PATCH_RADIUS: radius_reg <= mpd_pkg::RAD_REG_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_reg == '0) begin
      w_sat = CW'(1);
    end else if (CW'(width_reg) > MAX_W_C) begin
      w_sat = MAX_W_C;
    end else begin
      w_sat = CW'(width_reg);
    end
    if (height_reg == '0) begin
      h_sat = CW'(1);
    end else if (CW'(height_reg) > MAX_H_C) begin
      h_sat = MAX_H_C;
    end else begin
      h_sat = CW'(height_reg);
    end
    if (radius_reg == '0) begin
      r_sat = RW'(1);
    end else if (int'(radius_reg) > mpd_pkg::MAX_RADIUS) begin
      r_sat = RW'(mpd_pkg::MAX_RADIUS);
    end else begin
      r_sat = RW'(radius_reg);
    end
    r_pos = $signed({1'b0, r_sat});
  end

  assign write_ok = (command == mpd_pkg::CMD_WRITE) &&
                    (CW'(target_x) < MAX_W_C) && (CW'(target_y) < MAX_H_C);
  assign we       = in_accept && write_ok;
  assign waddr    = pix_addr(CW'(target_x), CW'(target_y));
  assign wdata    = {masked, red, green, blue};

  assign center_ok = (sx < w_sat) && (sy < h_sat);

  always_comb begin
    wx_t    = tx + mpd_pkg::coord_t'(dx);
    wy_t    = ty + mpd_pkg::coord_t'(dy);
    wx_s    = sx + mpd_pkg::coord_t'(dx);
    wy_s    = sy + mpd_pkg::coord_t'(dy);
    win_use = (state == S_WALK) &&
              (wx_t >= 0) && (wx_t < w_sat) && (wy_t >= 0) && (wy_t < h_sat) &&
              (wx_s >= 0) && (wx_s < w_sat) && (wy_s >= 0) && (wy_s < h_sat);
    raddr_t = win_use ? pix_addr(wx_t, wy_t) : '0;
    if (state == S_CHECK && center_ok) begin
      raddr_s = pix_addr(sx, sy);
    end else if (win_use) begin
      raddr_s = pix_addr(wx_s, wy_s);
    end else begin
      raddr_s = '0;
    end
  end

  mpd_ram #(
    .WIDTH (mpd_pkg::PIX_W),
    .DEPTH (mpd_pkg::DEPTH)
  ) u_ram_target (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_t),
    .rdata (rdata_t)
  );

  mpd_ram #(
    .WIDTH (mpd_pkg::PIX_W),
    .DEPTH (mpd_pkg::DEPTH)
  ) u_ram_source (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_s),
    .rdata (rdata_s)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dch[c] = $signed({1'b0, rdata_t[c*CHAN_W +: CHAN_W]}) -
               $signed({1'b0, rdata_s[c*CHAN_W +: CHAN_W]});
      pch[c] = dch[c] * dch[c];
      sq_next[c] = SQ_W'(pch[c]);
    end
    pair_ok = p1_valid && p1_use &&
              !rdata_t[mpd_pkg::MASK_BIT] && !rdata_s[mpd_pkg::MASK_BIT];
    sq3 = SQ3_W'(sq[0]) + SQ3_W'(sq[1]) + SQ3_W'(sq[2]);
  end

  always_comb begin
    rem_sh   = {rem, quo[DIVD_W-1]};
    geq      = (rem_sh >= {1'b0, cnt_acc});
    rem_next = geq ? COUNT_W'(rem_sh - {1'b0, cnt_acc}) : COUNT_W'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_valid <= (state == S_WALK);
      p1_use   <= win_use;
      p2_valid <= pair_ok;
      sq       <= sq_next;
      if (p2_valid) begin
        sum_acc <= sum_acc + SUM_W'(sq3);
        cnt_acc <= cnt_acc + COUNT_W'(1);
      end

      if (state == S_FINISH && out_free) begin
        out_valid     <= 1'b1;
        mean_distance <= bad ? '0 : mpd_pkg::MEAN_OUT_W'(quo);
        squared_sum   <= mpd_pkg::SUM_OUT_W'(sum_acc);
        sample_count  <= mpd_pkg::COUNT_OUT_W'(cnt_acc);
        bad_match     <= bad;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept && command == mpd_pkg::CMD_QUERY) begin
            tx      <= CW'(target_x);
            ty      <= CW'(target_y);
            sx      <= CW'(source_x);
            sy      <= CW'(source_y);
            sum_acc <= '0;
            cnt_acc <= '0;
            bad     <= 1'b0;
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (center_ok) begin
            state <= S_CWAIT;
          end else begin
            bad   <= 1'b1;
            state <= S_FINISH;
          end
        end
        S_CWAIT: begin
          if (rdata_s[mpd_pkg::MASK_BIT]) begin
            bad   <= 1'b1;
            state <= S_FINISH;
          end else begin
            dx    <= -r_pos;
            dy    <= -r_pos;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (dx == r_pos) begin
            dx <= -r_pos;
            if (dy == r_pos) begin
              state <= S_DRAIN;
            end else begin
              dy <= dy + ONE_D;
            end
          end else begin
            dx <= dx + ONE_D;
          end
        end
        S_DRAIN: begin
          if (!p1_valid && !p2_valid) begin
            if (cnt_acc == '0) begin
              bad   <= 1'b1;
              state <= S_FINISH;
            end else begin
              quo     <= {sum_acc, {mpd_pkg::FRAC_W{1'b0}}};
              rem     <= '0;
              div_cnt <= DCNT_W'(DIVD_W);
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          quo     <= {quo[DIVD_W-2:0], geq};
          rem     <= rem_next;
          div_cnt <= div_cnt - DCNT_W'(1);
          if (div_cnt == DCNT_W'(1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MPD_ASSERT_IMP(a_div_rem_below_divisor, state == S_DIV, rem < cnt_acc,
                  "divider remainder not below sample count")
  `MPD_ASSERT_IMP(a_count_within_window, state != S_IDLE,
                  cnt_acc <= COUNT_W'(mpd_pkg::WIN_MAX), "sample count exceeds window size")
  `MPD_ASSERT_IMP(a_bad_result_zero, out_valid && bad_match,
                  squared_sum == '0 && sample_count == '0 && mean_distance == '0,
                  "bad result carries nonzero fields")
  `MPD_ASSERT_NEXT(a_finish_loads_output, state == S_FINISH && out_free,
                   out_valid && state == S_IDLE,
                   "finished query did not reach the output register")
  `MPD_ASSERT_IMP(a_no_write_during_query, we, state == S_IDLE,
                  "pixel write while a query runs")

endmodule
